// ----- hw/rtl/mawo_pkg.sv -----
package mawo_pkg;

  // Largest window the sample store can hold.
  localparam int unsigned MaxWindow = 256;

  // Derived widths.
  localparam int unsigned IdxW   = $clog2(MaxWindow);
  localparam int unsigned CntW   = $clog2(MaxWindow + 1);

  // Fixed field and state widths.
  localparam int unsigned ValueW = 32;
  localparam int unsigned EntryW = 40;
  localparam int unsigned SumW   = 48;
  localparam int unsigned AvgW   = 40;
  localparam int unsigned StepW  = $clog2(SumW);

  // Configuration port.
  localparam int unsigned CfgW     = 9;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [CfgW-1:0] WindowReset = CfgW'(16);

  // Word index of the window size register (byte address bit 2).
  localparam logic RegWindowSize = 1'b0;

  // Input word operation codes.
  localparam logic OpSample = 1'b0;
  localparam logic OpOffset = 1'b1;

endpackage

// ----- hw/rtl/mawo_in_if.sv -----
interface mawo_in_if;

  logic                                      valid;
  logic                                      ready;
  logic                                      opcode;
  logic signed [mawo_pkg::ValueW-1:0]        value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);

endinterface

// ----- hw/rtl/mawo_out_if.sv -----
interface mawo_out_if;

  logic                                      valid;
  logic                                      ready;
  logic signed [mawo_pkg::AvgW-1:0]          average;
  logic        [mawo_pkg::CntW-1:0]          fill_count;

  modport source (output valid, output average, output fill_count, input ready);
  modport sink   (input valid, input average, input fill_count, output ready);

endinterface

// ----- hw/rtl/moving_average_with_offset_unit.sv -----
// Moving average over the most recent window_size samples, kept in a circular
// store with a running 48-bit sum and a fill count. A sample word (opcode 0)
// replaces the oldest entry once the window is full, or grows the fill count
// until then, and yields one result word: the sum divided by the fill count,
// truncated toward zero, plus the fill count. An offset word (opcode 1) adds
// its value to every filled entry and to the sum once per entry; it yields no
// result. Entries wrap at 40 bits, the sum at 48 bits, the average keeps the
// low 40 bits of the quotient. A sample word passes from acceptance through
// store access and sum update (StSmpSub, StSmpAdd), taking the magnitude of
// the sum (StDivPrep) and a radix-2 restoring divider, one quotient bit per
// cycle (StDiv), before the output register is loaded in StDone.
// An offset word walks the filled entries (up to 256) in turn on the single
// read-modify-write path of the sample store; with an empty window it ends at
// once. The input is not ready while a word is being worked on, but a new word
// is taken while an earlier result still waits in the output register.
// Writing window_size (byte address 0) clears the window, the sum and the
// write position; a value of zero acts as a window of one and values above
// 256 act as 256. Write it only while the block is idle. The store itself is
// never swept: only entries below the fill count are ever used, so no
// clearing pass follows reset.
module moving_average_with_offset_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mawo_in_if.sink                           in_i,
  mawo_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mawo_pkg::ApbAddrW-1:0]     paddr,
  input  logic [mawo_pkg::ApbDataW-1:0]     pwdata,
  output logic [mawo_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    StIdle,
    StSmpSub,
    StSmpAdd,
    StDivPrep,
    StDiv,
    StDone,
    StOfs
  } state_e;

  // Control and arithmetic state.
  state_e                          state_q, state_d;
  logic [mawo_pkg::CfgW-1:0]       window_q, window_d;
  logic [mawo_pkg::IdxW-1:0]       widx_q, widx_d;
  logic [mawo_pkg::CntW-1:0]       filled_q, filled_d;
  logic [mawo_pkg::SumW-1:0]       sum_q, sum_d;
  logic [mawo_pkg::ValueW-1:0]     val_q, val_d;
  logic [mawo_pkg::SumW-1:0]       dq_q, dq_d;
  logic [mawo_pkg::CntW-1:0]       rem_q, rem_d;
  logic [mawo_pkg::StepW-1:0]      step_q, step_d;
  logic                            neg_q, neg_d;
  logic [mawo_pkg::IdxW-1:0]       ptr_q, ptr_d;
  logic                            out_vld_q, out_vld_d;
  logic [mawo_pkg::AvgW-1:0]       avg_q, avg_d;
  logic [mawo_pkg::CntW-1:0]       cnt_q, cnt_d;

  // Sample store.
  logic [mawo_pkg::EntryW-1:0]     ring_mem [mawo_pkg::MaxWindow];
  logic [mawo_pkg::EntryW-1:0]     rd_data_q;
  logic                            mem_we;
  logic [mawo_pkg::IdxW-1:0]       mem_waddr;
  logic [mawo_pkg::IdxW-1:0]       mem_raddr;
  logic [mawo_pkg::EntryW-1:0]     mem_wdata;

  logic [mawo_pkg::CntW-1:0]       eff_size;
  logic                            full;
  logic                            in_acc;
  logic                            cfg_we;
  logic [mawo_pkg::SumW-1:0]       val_ext;
  logic [mawo_pkg::SumW-1:0]       old_ext;
  logic [mawo_pkg::EntryW-1:0]     entry_val;
  logic                            add_sub;
  logic [mawo_pkg::SumW-1:0]       add_op;
  logic [mawo_pkg::SumW-1:0]       add_res;
  logic [mawo_pkg::CntW:0]         trial;
  logic [mawo_pkg::CntW:0]         diff;
  logic                            ge;
  logic [mawo_pkg::CntW-1:0]       widx_inc;
  logic [mawo_pkg::CntW-1:0]       ptr_inc;
  logic [mawo_pkg::AvgW-1:0]       q_low;

  function automatic logic [mawo_pkg::CfgW-1:0] pwpick(input logic [mawo_pkg::ApbDataW-1:0] d);
    pwpick = d[mawo_pkg::CfgW-1:0];
  endfunction

  // Configuration port: single register, always ready.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == mawo_pkg::RegWindowSize);
  assign prdata = (paddr[2] == mawo_pkg::RegWindowSize)
                ? {{(mawo_pkg::ApbDataW - mawo_pkg::CfgW){1'b0}}, window_q}
                : '0;

  // A window of zero acts as one, and anything above the store depth is clipped.
  always_comb begin
    if (window_q == '0) begin
      eff_size = mawo_pkg::CntW'(1);
    end else if (32'(window_q) > 32'(mawo_pkg::MaxWindow)) begin
      eff_size = mawo_pkg::CntW'(mawo_pkg::MaxWindow);
    end else begin
      eff_size = mawo_pkg::CntW'(window_q);
    end
  end

  assign full      = (filled_q == eff_size);
  assign in_i.ready = (state_q == StIdle);
  assign in_acc    = in_i.valid && in_i.ready;

  assign val_ext   = {{(mawo_pkg::SumW - mawo_pkg::ValueW){val_q[mawo_pkg::ValueW-1]}}, val_q};
  assign old_ext   = {{(mawo_pkg::SumW - mawo_pkg::EntryW){rd_data_q[mawo_pkg::EntryW-1]}},
                      rd_data_q};
  assign entry_val = val_ext[mawo_pkg::EntryW-1:0];

  // The one wide adder, shared by the sum update of both word kinds.
  assign add_res = sum_q + (add_sub ? ~add_op : add_op) + mawo_pkg::SumW'(add_sub);

  // One step of the restoring divider: shift in the next dividend bit and
  // subtract the fill count when it fits.
  assign trial = {rem_q, dq_q[mawo_pkg::SumW-1]};
  assign diff  = trial - {1'b0, filled_q};
  assign ge    = (trial >= {1'b0, filled_q});

  assign widx_inc = mawo_pkg::CntW'(widx_q) + mawo_pkg::CntW'(1);
  assign ptr_inc  = mawo_pkg::CntW'(ptr_q) + mawo_pkg::CntW'(1);
  assign q_low    = dq_q[mawo_pkg::AvgW-1:0];

  always_comb begin
    state_d   = state_q;
    window_d  = window_q;
    widx_d    = widx_q;
    filled_d  = filled_q;
    sum_d     = sum_q;
    val_d     = val_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    step_d    = step_q;
    neg_d     = neg_q;
    ptr_d     = ptr_q;
    avg_d     = avg_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && !out_o.ready;
    mem_we    = 1'b0;
    mem_waddr = widx_q;
    mem_wdata = entry_val;
    mem_raddr = widx_q;
    add_sub   = 1'b0;
    add_op    = val_ext;

    case (state_q)
      StIdle: begin
        // Offsets walk the store from entry zero; samples look at the oldest.
        mem_raddr = (in_i.opcode == mawo_pkg::OpOffset) ? '0 : widx_q;
        if (in_acc) begin
          val_d = in_i.value;
          if (in_i.opcode == mawo_pkg::OpOffset) begin
            ptr_d = '0;
            if (filled_q != '0) begin
              state_d = StOfs;
            end
          end else begin
            state_d = StSmpSub;
          end
        end
      end
      StSmpSub: begin
        // The oldest entry read last cycle leaves the sum once the window is full.
        if (full) begin
          add_sub = 1'b1;
          add_op  = old_ext;
          sum_d   = add_res;
        end else begin
          filled_d = filled_q + mawo_pkg::CntW'(1);
        end
        state_d = StSmpAdd;
      end
      StSmpAdd: begin
        mem_we = 1'b1;
        sum_d  = add_res;
        if (widx_inc >= eff_size) begin
          widx_d = '0;
        end else begin
          widx_d = widx_inc[mawo_pkg::IdxW-1:0];
        end
        state_d = StDivPrep;
      end
      StDivPrep: begin
        neg_d   = sum_q[mawo_pkg::SumW-1];
        dq_d    = sum_q[mawo_pkg::SumW-1] ? (~sum_q + mawo_pkg::SumW'(1)) : sum_q;
        rem_d   = '0;
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d  = ge ? diff[mawo_pkg::CntW-1:0] : trial[mawo_pkg::CntW-1:0];
        dq_d   = {dq_q[mawo_pkg::SumW-2:0], ge};
        step_d = step_q + mawo_pkg::StepW'(1);
        if (step_q == mawo_pkg::StepW'(mawo_pkg::SumW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Wait here only while an earlier result has not been taken.
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          avg_d     = neg_q ? (~q_low + mawo_pkg::AvgW'(1)) : q_low;
          cnt_d     = filled_q;
          state_d   = StIdle;
        end
      end
      StOfs: begin
        // Entry ptr was read last cycle; write it back corrected and fetch the next.
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rd_data_q + entry_val;
        mem_raddr = ptr_inc[mawo_pkg::IdxW-1:0];
        sum_d     = add_res;
        if (ptr_inc == filled_q) begin
          state_d = StIdle;
        end else begin
          ptr_d = ptr_inc[mawo_pkg::IdxW-1:0];
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A window size write restarts the filter.
    if (cfg_we) begin
      window_d = pwpick(pwdata);
      widx_d   = '0;
      filled_d = '0;
      sum_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      window_q  <= mawo_pkg::WindowReset;
      widx_q    <= '0;
      filled_q  <= '0;
      sum_q     <= '0;
      step_q    <= '0;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      window_q  <= window_d;
      widx_q    <= widx_d;
      filled_q  <= filled_d;
      sum_q     <= sum_d;
      step_q    <= step_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    avg_q <= avg_d;
    cnt_q <= cnt_d;
  end

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= ring_mem[mem_raddr];
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.average    = avg_q;
  assign out_o.fill_count = cnt_q;

  // The fill count never runs past the effective window.
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= eff_size)
    else $error("fill count exceeds window size");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) && (filled_q != '0) |-> rem_q < filled_q)
    else $error("divider remainder out of range");

  // An offset word never changes how many samples are held.
  a_ofs_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.opcode == mawo_pkg::OpOffset) && !cfg_we |=> $stable(filled_q))
    else $error("offset word changed the fill count");

  // A new result appears only as the sequencer returns to idle.
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> state_q == StIdle)
    else $error("result raised outside of completion");

endmodule
